// ===== rtl/core/tws_pkg.sv =====
// Shared types, constants and codes of the time-window playlist sequencer.
package tws_pkg;

  localparam int DEF_MAX_ENTRIES = 128;

  // Timing constants.
  localparam logic [31:0] CHECK_PERIOD_MS        = 32'd1000;
  localparam logic [31:0] UNIT_MS                = 32'd100;
  localparam logic [15:0] FALLBACK_RECHECK_UNITS = 16'd10;
  localparam logic [15:0] DWELL_DEFAULT          = 16'd100;

  // Input transaction kinds.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Result actions.
  localparam logic [2:0] ACT_NONE          = 3'd0;
  localparam logic [2:0] ACT_APPLY_ENTRY   = 3'd1;
  localparam logic [2:0] ACT_APPLY_DEFAULT = 3'd2;
  localparam logic [2:0] ACT_HOLD          = 3'd3;
  localparam logic [2:0] ACT_ENDED         = 3'd4;

  // Configuration register indexes.
  localparam logic [7:0] CFG_ENTRY_COUNT    = 8'd0;
  localparam logic [7:0] CFG_REPEAT_LIMIT   = 8'd1;
  localparam logic [7:0] CFG_END_PRESET     = 8'd2;
  localparam logic [7:0] CFG_DEFAULT_PRESET = 8'd3;

  // One stored playlist entry.
  typedef struct packed {
    logic [31:0] transition;
    logic [10:0] win_end;
    logic [10:0] win_start;
    logic        win_en;
    logic [15:0] dwell;
    logic [7:0]  preset;
  } entry_t;

endpackage

// ===== rtl/core/time_window_playlist_sequencer.sv =====
// Top level of the time-window playlist sequencer: handshakes, sequencer and state.
// Every input transaction returns exactly one result transaction. A write or start
// transaction goes from acceptance straight to the result state. A tick scans up to len
// entries, where len is min(entry_count, MAX_ENTRIES): the round-robin scan reads the
// entry memory through its single read port, one entry per cycle, and tests each
// through one shared window checker. When the slot after the current one lies at or
// beyond len, the next-index reduction subtracts len from it repeatedly. Ticks that
// find no due check and no expired dwell go from S_CHK through S_EXP to the result.
// The input side is ready whenever the sequencer is idle, even while a finished result
// still waits in the output register. No clearing pass is needed after reset; entries
// are defined by writing them before a start transaction.
module time_window_playlist_sequencer
  import tws_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input transaction channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [6:0]  in_entry_index,
  input  logic [7:0]  in_entry_preset,
  input  logic [15:0] in_entry_dwell,
  input  logic [31:0] in_entry_transition,
  input  logic        in_window_enable,
  input  logic [10:0] in_window_start,
  input  logic [10:0] in_window_end,
  input  logic [31:0] in_now_ms,
  input  logic [10:0] in_now_minute,
  // Result transaction channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_action,
  output logic [7:0]  out_preset_out,
  output logic [31:0] out_transition_out,
  output logic [6:0]  out_index_out,
  output logic        out_in_fallback,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // Slot index width, a width that can also hold the entry count itself, and a widened index width.
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int LW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = IW + 7;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_CUR  = 3'd2;
  localparam logic [2:0] S_EXP  = 3'd3;
  localparam logic [2:0] S_MOD  = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // Control state.
  logic [2:0]    state_r, state_nxt;
  logic          running_r, running_nxt;
  logic [IW-1:0] cs_r, cs_nxt;
  logic          slot_valid_r, slot_valid_nxt;
  logic          fb_r, fb_nxt;
  logic [15:0]   dwell_r, dwell_nxt;
  logic [31:0]   last_switch_r, last_switch_nxt;
  logic [31:0]   last_check_r, last_check_nxt;
  logic [8:0]    rc_r, rc_nxt;
  logic [7:0]    count_r, count_nxt;
  logic [7:0]    rlim_r, rlim_nxt;
  logic [7:0]    endp_r, endp_nxt;
  logic [7:0]    defp_r, defp_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Per-tick working registers.
  logic [31:0]   now_r, now_nxt;
  logic [10:0]   minute_r, minute_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          force_r, force_nxt;
  logic          probe_r, probe_nxt;
  logic          probe_fail_r, probe_fail_nxt;
  logic [22:0]   dwell_ms_r, dwell_ms_nxt;
  logic [LW-1:0] mod_r, mod_nxt;
  logic [IW-1:0] iss_idx_r, iss_idx_nxt;
  logic [LW-1:0] iss_cnt_r, iss_cnt_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;

  // Pending result and output register.
  logic [2:0]    res_action_r, res_action_nxt;
  logic [7:0]    res_preset_r, res_preset_nxt;
  logic [31:0]   res_trans_r, res_trans_nxt;
  logic [6:0]    res_index_r, res_index_nxt;
  logic [2:0]    out_action_r;
  logic [7:0]    out_preset_r;
  logic [31:0]   out_trans_r;
  logic [6:0]    out_index_r;
  logic          out_fb_r;
  logic          out_load;

  // Memory, window checker and elapsed-time unit.
  logic          in_acc;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  entry_t        rd_data;
  logic          allowed;
  logic [31:0]   el_since;
  logic [31:0]   el_thr;
  logic          el_reached;
  logic [8:0]    eff9;
  logic [LW-1:0] eff_len;
  logic          expired;
  logic          rolled;
  logic [XW-1:0] sel_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  // Effective entry count, never above the table depth.
  assign eff9    = ({1'b0, count_r} < 9'(MAX_ENTRIES)) ? {1'b0, count_r} : 9'(MAX_ENTRIES);
  assign eff_len = eff9[LW-1:0];

  // Entry writes go straight to memory at the accepting edge; out-of-range slots drop.
  assign wr_en   = in_acc && (in_kind == KIND_WRITE) &&
                   (9'(in_entry_index) < 9'(MAX_ENTRIES));
  assign wr_addr = IW'(in_entry_index);

  always_comb begin
    wr_data.preset     = in_entry_preset;
    wr_data.dwell      = (in_entry_dwell <= 16'd1) ? DWELL_DEFAULT : in_entry_dwell;
    wr_data.win_en     = in_window_enable;
    wr_data.win_start  = in_window_start;
    wr_data.win_end    = in_window_end;
    wr_data.transition = in_entry_transition;
  end

  tws_entry_ram #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tws_window_check u_win (
    .entry   (rd_data),
    .minute  (minute_r),
    .allowed (allowed)
  );

  // The elapsed unit serves the once-per-second check and the dwell test.
  assign el_since = (state_r == S_CHK) ? last_check_r : last_switch_r;
  assign el_thr   = (state_r == S_CHK) ? CHECK_PERIOD_MS : 32'(dwell_ms_r);

  tws_elapsed u_elapsed (
    .now       (now_r),
    .since     (el_since),
    .threshold (el_thr),
    .reached   (el_reached)
  );

  assign expired = !slot_valid_r || el_reached;
  // A pass wraps when a current slot exists and the selected slot does not lie beyond it.
  assign rolled  = slot_valid_r && (chk_idx_r <= cs_r);
  assign sel_ext = XW'(chk_idx_r);

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt       = state_r;
    running_nxt     = running_r;
    cs_nxt          = cs_r;
    slot_valid_nxt  = slot_valid_r;
    fb_nxt          = fb_r;
    dwell_nxt       = dwell_r;
    last_switch_nxt = last_switch_r;
    last_check_nxt  = last_check_r;
    rc_nxt          = rc_r;
    count_nxt       = count_r;
    rlim_nxt        = rlim_r;
    endp_nxt        = endp_r;
    defp_nxt        = defp_r;
    now_nxt         = now_r;
    minute_nxt      = minute_r;
    len_nxt         = len_r;
    force_nxt       = force_r;
    probe_nxt       = probe_r;
    probe_fail_nxt  = probe_fail_r;
    dwell_ms_nxt    = dwell_ms_r;
    mod_nxt         = mod_r;
    iss_idx_nxt     = iss_idx_r;
    iss_cnt_nxt     = iss_cnt_r;
    chk_vld_nxt     = chk_vld_r;
    chk_idx_nxt     = chk_idx_r;
    res_action_nxt  = res_action_r;
    res_preset_nxt  = res_preset_r;
    res_trans_nxt   = res_trans_r;
    res_index_nxt   = res_index_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    rd_en           = 1'b0;
    rd_addr         = cs_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENTRY_COUNT:    count_nxt = cfg_data;
        CFG_REPEAT_LIMIT:   rlim_nxt  = cfg_data;
        CFG_END_PRESET:     endp_nxt  = cfg_data;
        CFG_DEFAULT_PRESET: defp_nxt  = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_action_nxt = ACT_NONE;
          res_preset_nxt = 8'd0;
          res_trans_nxt  = 32'd0;
          res_index_nxt  = 7'd0;
          now_nxt        = in_now_ms;
          minute_nxt     = in_now_minute;
          len_nxt        = eff_len;
          state_nxt      = S_OUT;
          case (in_kind)
            KIND_START: begin
              running_nxt    = 1'b1;
              slot_valid_nxt = 1'b0;
              cs_nxt         = '0;
              fb_nxt         = 1'b0;
              dwell_nxt      = 16'd0;
              rc_nxt         = (rlim_r != 8'd0) ? (9'(rlim_r) + 9'd1) : 9'd0;
            end
            KIND_TICK: begin
              if (running_r && (eff_len != '0)) begin
                state_nxt = S_CHK;
              end
            end
            default: ;
          endcase
        end
      end

      S_CHK: begin
        force_nxt      = 1'b0;
        probe_fail_nxt = 1'b0;
        dwell_ms_nxt   = 23'(dwell_r) * 23'(UNIT_MS);
        state_nxt      = S_EXP;
        if (el_reached) begin
          last_check_nxt = now_r;
          if (fb_r) begin
            // In fallback, probe the whole table from slot zero.
            probe_nxt   = 1'b1;
            iss_idx_nxt = '0;
            iss_cnt_nxt = '0;
            chk_vld_nxt = 1'b0;
            state_nxt   = S_SCAN;
          end else if (slot_valid_r && (LW'(cs_r) < len_r)) begin
            rd_en     = 1'b1;
            rd_addr   = cs_r;
            state_nxt = S_CUR;
          end
        end
      end

      S_CUR: begin
        force_nxt = !allowed;
        state_nxt = S_EXP;
      end

      S_EXP: begin
        if (!expired && !force_r) begin
          state_nxt = S_OUT;
        end else begin
          last_switch_nxt = now_r;
          if (probe_fail_r) begin
            // The probe already showed that no entry is allowed.
            res_action_nxt = (defp_r != 8'd0 && !fb_r) ? ACT_APPLY_DEFAULT : ACT_HOLD;
            res_preset_nxt = (defp_r != 8'd0 && !fb_r) ? defp_r : 8'd0;
            fb_nxt         = 1'b1;
            dwell_nxt      = FALLBACK_RECHECK_UNITS;
            state_nxt      = S_OUT;
          end else if (!fb_r && slot_valid_r) begin
            mod_nxt   = LW'(cs_r) + LW'(1);
            state_nxt = S_MOD;
          end else begin
            probe_nxt   = 1'b0;
            iss_idx_nxt = '0;
            iss_cnt_nxt = '0;
            chk_vld_nxt = 1'b0;
            state_nxt   = S_SCAN;
          end
        end
      end

      S_MOD: begin
        // Reduce the next slot modulo len by repeated subtraction.
        if (mod_r >= len_r) begin
          mod_nxt = mod_r - len_r;
        end else begin
          probe_nxt   = 1'b0;
          iss_idx_nxt = mod_r[IW-1:0];
          iss_cnt_nxt = '0;
          chk_vld_nxt = 1'b0;
          state_nxt   = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue side: one read per cycle, round robin over len slots.
        if (iss_cnt_r < len_r) begin
          rd_en       = 1'b1;
          rd_addr     = iss_idx_r;
          iss_idx_nxt = ((LW'(iss_idx_r) + LW'(1)) == len_r) ? '0 : (iss_idx_r + IW'(1));
          iss_cnt_nxt = iss_cnt_r + LW'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = iss_idx_r;
        end else begin
          chk_vld_nxt = 1'b0;
        end
        // Check side: the entry read in the previous cycle.
        if (chk_vld_r && allowed) begin
          last_switch_nxt = now_r;
          fb_nxt          = 1'b0;
          state_nxt       = S_OUT;
          if (rolled && (rc_r == 9'd1)) begin
            running_nxt    = 1'b0;
            slot_valid_nxt = 1'b0;
            cs_nxt         = '0;
            dwell_nxt      = 16'd0;
            rc_nxt         = 9'd0;
            res_action_nxt = ACT_ENDED;
            res_preset_nxt = endp_r;
          end else begin
            if (rolled && (rc_r > 9'd1)) begin
              rc_nxt = rc_r - 9'd1;
            end
            cs_nxt         = chk_idx_r;
            slot_valid_nxt = 1'b1;
            dwell_nxt      = rd_data.dwell;
            res_action_nxt = ACT_APPLY_ENTRY;
            res_preset_nxt = rd_data.preset;
            res_trans_nxt  = rd_data.transition;
            res_index_nxt  = sel_ext[6:0];
          end
        end else if (!chk_vld_r && (iss_cnt_r == len_r)) begin
          if (probe_r) begin
            probe_fail_nxt = 1'b1;
            state_nxt      = S_EXP;
          end else begin
            res_action_nxt = (defp_r != 8'd0 && !fb_r) ? ACT_APPLY_DEFAULT : ACT_HOLD;
            res_preset_nxt = (defp_r != 8'd0 && !fb_r) ? defp_r : 8'd0;
            fb_nxt         = 1'b1;
            dwell_nxt      = FALLBACK_RECHECK_UNITS;
            state_nxt      = S_OUT;
          end
        end
      end

      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      running_r     <= 1'b0;
      cs_r          <= '0;
      slot_valid_r  <= 1'b0;
      fb_r          <= 1'b0;
      dwell_r       <= 16'd0;
      last_switch_r <= 32'd0;
      last_check_r  <= 32'd0;
      rc_r          <= 9'd0;
      count_r       <= 8'd1;
      rlim_r        <= 8'd0;
      endp_r        <= 8'd0;
      defp_r        <= 8'd0;
      out_valid_r   <= 1'b0;
      force_r       <= 1'b0;
      probe_r       <= 1'b0;
      probe_fail_r  <= 1'b0;
      iss_cnt_r     <= '0;
      chk_vld_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      running_r     <= running_nxt;
      cs_r          <= cs_nxt;
      slot_valid_r  <= slot_valid_nxt;
      fb_r          <= fb_nxt;
      dwell_r       <= dwell_nxt;
      last_switch_r <= last_switch_nxt;
      last_check_r  <= last_check_nxt;
      rc_r          <= rc_nxt;
      count_r       <= count_nxt;
      rlim_r        <= rlim_nxt;
      endp_r        <= endp_nxt;
      defp_r        <= defp_nxt;
      out_valid_r   <= out_valid_nxt;
      force_r       <= force_nxt;
      probe_r       <= probe_nxt;
      probe_fail_r  <= probe_fail_nxt;
      iss_cnt_r     <= iss_cnt_nxt;
      chk_vld_r     <= chk_vld_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    now_r        <= now_nxt;
    minute_r     <= minute_nxt;
    len_r        <= len_nxt;
    dwell_ms_r   <= dwell_ms_nxt;
    mod_r        <= mod_nxt;
    iss_idx_r    <= iss_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    res_action_r <= res_action_nxt;
    res_preset_r <= res_preset_nxt;
    res_trans_r  <= res_trans_nxt;
    res_index_r  <= res_index_nxt;
    if (out_load) begin
      out_action_r <= res_action_r;
      out_preset_r <= res_preset_r;
      out_trans_r  <= res_trans_r;
      out_index_r  <= res_index_r;
      out_fb_r     <= fb_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = out_action_r;
  assign out_preset_out     = out_preset_r;
  assign out_transition_out = out_trans_r;
  assign out_index_out      = out_index_r;
  assign out_in_fallback    = out_fb_r;

  // A current slot only exists while the playlist is running.
  a_slot_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    slot_valid_r |-> running_r)
    else $error("slot valid while playlist is stopped");

  // The scan never issues more reads than there are entries in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (iss_cnt_r <= len_r))
    else $error("scan ran past the entry count");

  // Fallback results report the fallback flag; an ended playlist is not in fallback.
  a_fallback_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_action == ACT_APPLY_DEFAULT) || (out_action == ACT_HOLD)))
      |-> out_in_fallback)
    else $error("fallback action without fallback flag");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (res_action_r == ACT_ENDED) |-> !running_r && !fb_r)
    else $error("playlist end left the sequencer armed");

endmodule

// ===== rtl/core/tws_entry_ram.sv =====
// Playlist entry memory with one write port and one registered read port.
module tws_entry_ram
  import tws_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_ENTRIES,
  parameter int AW    = $clog2(DEF_MAX_ENTRIES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/tws_window_check.sv =====
// Daily minute window test of one entry against the current minute.
module tws_window_check
  import tws_pkg::*;
(
  input  entry_t      entry,
  input  logic [10:0] minute,
  output logic        allowed
);

  always_comb begin
    if (!entry.win_en || (entry.win_start == entry.win_end)) begin
      allowed = 1'b1;
    end else if (entry.win_start < entry.win_end) begin
      allowed = (minute >= entry.win_start) && (minute < entry.win_end);
    end else begin
      // The window wraps past midnight.
      allowed = (minute >= entry.win_start) || (minute < entry.win_end);
    end
  end

endmodule

// ===== rtl/core/tws_elapsed.sv =====
// Shared wrapping elapsed-time compare: (now - since) >= threshold.
module tws_elapsed (
  input  logic [31:0] now,
  input  logic [31:0] since,
  input  logic [31:0] threshold,
  output logic        reached
);

  logic [31:0] diff;

  assign diff    = now - since;
  assign reached = diff >= threshold;

endmodule
